// ===== rtl/vector3_alu_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-component vector ALU.
// The checker that uses them has clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ALU_ASSERT_SVH
`define VECTOR3_ALU_ASSERT_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define V3A_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds after the delay given by argument n.
`define V3A_ASSERT_DLY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

// ===== rtl/v3alu_pkg.sv =====
// ----------------------------------------------------------------------------
// v3alu_pkg
// Types, constants and helpers shared by the vector ALU modules.
// ----------------------------------------------------------------------------
package v3alu_pkg;

  // Q16.16 data format.
  localparam int DW = 32;
  localparam int FB = 16;
  // Width of the divider numerator, a magnitude shifted up by the fraction.
  localparam int NW = DW + FB;
  // Width wide enough for every intermediate sum before saturation.
  localparam int WIDE = 2 * DW + 2;

  // Pipeline depths: one root bit per stage, a range check plus one
  // quotient bit per stage.
  localparam int SQ_ST = DW;
  localparam int DV_ST = DW + 1;
  localparam int SIDE_LEN = SQ_ST + DV_ST;
  // Index of the final result register in the valid line.
  localparam int LAT = SQ_ST + DV_ST + 3;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [WIDE-1:0] wide_t;
  typedef logic signed [2*DW-1:0] prod_t;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_SCALE = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_DOT   = 3'd4,
    CMD_CROSS = 3'd5,
    CMD_MAG   = 3'd6,
    CMD_NORM  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e  cmd;
    word_t ax;
    word_t ay;
    word_t az;
    word_t bx;
    word_t by;
    word_t bz;
    word_t scalar_in;
  } item_t;

  typedef struct packed {
    word_t   rx;
    word_t   ry;
    word_t   rz;
    word_t   scalar_out;
    status_e status;
  } result_t;

  // Operands of one lane: its own components and the two others for cross.
  typedef struct packed {
    cmd_e  cmd;
    word_t a_i;
    word_t b_i;
    word_t a_j;
    word_t a_k;
    word_t b_j;
    word_t b_k;
    word_t s;
  } lane_in_t;

  // A saturated value and whether it was clamped.
  typedef struct packed {
    logic  flag;
    word_t val;
  } sat_t;

  // Per-item data that travels beside the root and divide pipelines.
  typedef struct packed {
    cmd_e            cmd;
    word_t [2:0]     res;
    word_t           dot;
    logic            flag;
    word_t [2:0]     a;
    logic            s_neg;
    logic            s_zero;
    logic [DW-1:0]   s_abs;
  } side_t;

  // Clamp a wide signed value to the data range.
  function automatic sat_t sat_wide(input wide_t v);
    wide_t hi;
    wide_t lo;
    sat_t  r;
    hi = wide_t'({(DW-1){1'b1}});
    lo = ~hi;
    r.flag = 1'b0;
    r.val  = v[DW-1:0];
    if (v > hi) begin
      r.flag = 1'b1;
      r.val  = hi[DW-1:0];
    end else if (v < lo) begin
      r.flag = 1'b1;
      r.val  = lo[DW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/v3alu_lane.sv =====
// ----------------------------------------------------------------------------
// v3alu_lane
// One component lane: multiplies, adds or subtracts in the first stage, then rounds and
// saturates the add, subtract, scale and cross results in the second.
// ----------------------------------------------------------------------------
module v3alu_lane import v3alu_pkg::*; (
  input  logic     clk_i,
  input  lane_in_t lane_i,
  output prod_t    prod_o,
  output sat_t     res_o
);

  word_t           opa;
  word_t           opb;
  prod_t           m1_d, m1_q;
  prod_t           m2_d, m2_q;
  logic signed [DW:0]   as_d, as_q;
  cmd_e            cmd_q;
  logic signed [2*DW:0] diff;
  sat_t            res_d, res_q;

  // Operand selection for the main product of this lane.
  always_comb begin
    opa = (lane_i.cmd == CMD_CROSS) ? lane_i.a_j : lane_i.a_i;
    unique case (lane_i.cmd)
      CMD_SCALE: opb = lane_i.s;
      CMD_DOT:   opb = lane_i.b_i;
      CMD_CROSS: opb = lane_i.b_k;
      default:   opb = lane_i.a_i;
    endcase
  end

  assign m1_d = opa * opb;
  assign m2_d = lane_i.a_k * lane_i.b_j;
  assign as_d = (lane_i.cmd == CMD_SUB) ? lane_i.a_i - lane_i.b_i
                                        : lane_i.a_i + lane_i.b_i;

  // First stage: products and the sum or difference.
  always_ff @(posedge clk_i) begin
    m1_q  <= m1_d;
    m2_q  <= m2_d;
    as_q  <= as_d;
    cmd_q <= lane_i.cmd;
  end

  // Second stage: floor shift of the products, then saturation.
  always_comb begin
    diff = m1_q - m2_q;
    unique case (cmd_q)
      CMD_ADD, CMD_SUB: res_d = sat_wide(wide_t'(as_q));
      CMD_SCALE:        res_d = sat_wide(wide_t'(m1_q >>> FB));
      CMD_CROSS:        res_d = sat_wide(wide_t'(diff >>> FB));
      default:          res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign prod_o = m1_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/v3alu_sqrt.sv =====
// ----------------------------------------------------------------------------
// v3alu_sqrt
// Pipelined integer square root: one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module v3alu_sqrt import v3alu_pkg::*; (
  input  logic            clk_i,
  input  logic [2*DW-1:0] n_i,
  output logic [DW-1:0]   root_o
);

  logic [2*DW-1:0] rem_q  [SQ_ST];
  logic [DW-1:0]   root_q [SQ_ST];

  // Each stage tries to set one root bit, highest first.
  for (genvar j = 0; j < SQ_ST; j++) begin : g_st
    localparam int K = SQ_ST - 1 - j;
    logic [2*DW-1:0] rin;
    logic [DW-1:0]   qin;
    logic [2*DW+1:0] incr;

    if (j == 0) begin : g_first
      assign rin = n_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign qin = root_q[j-1];
    end

    // (root + 2^K)^2 - root^2
    assign incr = ((2*DW+2)'(qin) << (K + 1)) + ((2*DW+2)'(1) << (2 * K));

    always_ff @(posedge clk_i) begin
      if ((2*DW+2)'(rin) >= incr) begin
        rem_q[j]  <= rin - incr[2*DW-1:0];
        root_q[j] <= qin | (DW'(1) << K);
      end else begin
        rem_q[j]  <= rin;
        root_q[j] <= qin;
      end
    end
  end

  assign root_o = root_q[SQ_ST-1];

endmodule

// ===== rtl/v3alu_div.sv =====
// ----------------------------------------------------------------------------
// v3alu_div
// Pipelined unsigned divider: a range check stage, then one quotient bit
// per stage. Quotients that do not fit the data width raise ovf_o.
// ----------------------------------------------------------------------------
module v3alu_div import v3alu_pkg::*; (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [DW-1:0] quo_o,
  output logic          ovf_o
);

  logic [NW-1:0] rem_q [DV_ST];
  logic [DW-1:0] den_q [DV_ST];
  logic [DW-1:0] quo_q [DV_ST];
  logic          ovf_q [DV_ST];

  // Range check: the quotient needs more than DW bits when the numerator
  // reaches the denominator shifted up by DW.
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    ovf_q[0] <= DW'(num_i[NW-1:DW]) >= den_i;
  end

  // Restoring division, highest quotient bit first.
  for (genvar j = 1; j < DV_ST; j++) begin : g_st
    localparam int K = DV_ST - 1 - j;
    logic [2*DW-1:0] trial;

    assign trial = (2*DW)'(den_q[j-1]) << K;

    always_ff @(posedge clk_i) begin
      den_q[j] <= den_q[j-1];
      ovf_q[j] <= ovf_q[j-1];
      if ((2*DW)'(rem_q[j-1]) >= trial) begin
        rem_q[j] <= rem_q[j-1] - trial[NW-1:0];
        quo_q[j] <= quo_q[j-1] | (DW'(1) << K);
      end else begin
        rem_q[j] <= rem_q[j-1];
        quo_q[j] <= quo_q[j-1];
      end
    end
  end

  assign quo_o = quo_q[DV_ST-1];
  assign ovf_o = ovf_q[DV_ST-1];

endmodule

// ===== rtl/vector3_alu.sv =====
// ----------------------------------------------------------------------------
// vector3_alu
// Three-component vector ALU on signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction enters when start is high and busy is low. busy is high
//   only while rst_ni is low, so a new transaction may enter on every cycle.
//   Each transaction yields exactly one result, shown on result_o for one
//   cycle with result_valid_o high. Results leave in the order of entry.
// Depth and throughput:
//   The depth is set by the 32-stage square root that feeds the 33-stage
//   divider; every command travels the full depth. Throughput is one
//   transaction per cycle.
// Reset:
//   rst_ni clears the valid pipeline at once; transactions in flight are
//   dropped and no result is shown for them.
// Receiver:
//   The receiver cannot stall; it must take each result in its cycle.
// ----------------------------------------------------------------------------
module vector3_alu import v3alu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output result_t result_o,
  output logic    result_valid_o
);

  logic [LAT:0]    vld_q;
  item_t           item0_q, item1_q, item2_q;
  word_t           va [3];
  word_t           vb [3];
  prod_t           prod [3];
  sat_t            lres [3];
  wide_t           dot_d, dot_q;
  logic [2*DW-1:0] sumsq_d, sumsq_q;
  sat_t            dot_sat;
  side_t           side_d;
  side_t           side_q [SIDE_LEN];
  logic [DW-1:0]   root;
  logic [DW-1:0]   mag_q [DV_ST];
  side_t           tap;
  side_t           fin;
  logic [DW-1:0]   quo [3];
  logic            ovf [3];
  sat_t            dres [3];
  logic [DW-1:0]   mfin;
  result_t         result_d, result_q;
  logic            flag;

  // No transaction is taken while the block is held in reset.
  assign busy = ~rst_ni;

  // Valid line, one bit per pipeline stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-1:0], start};
    end
  end

  // Input register and operand copies for the merge stage.
  always_ff @(posedge clk_i) begin
    item0_q <= item_i;
    item1_q <= item0_q;
    item2_q <= item1_q;
  end

  assign va[0] = item0_q.ax;
  assign va[1] = item0_q.ay;
  assign va[2] = item0_q.az;
  assign vb[0] = item0_q.bx;
  assign vb[1] = item0_q.by;
  assign vb[2] = item0_q.bz;

  // Component lanes.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    lane_in_t lin;
    assign lin.cmd = item0_q.cmd;
    assign lin.a_i = va[i];
    assign lin.b_i = vb[i];
    assign lin.a_j = va[(i + 1) % 3];
    assign lin.a_k = va[(i + 2) % 3];
    assign lin.b_j = vb[(i + 1) % 3];
    assign lin.b_k = vb[(i + 2) % 3];
    assign lin.s   = item0_q.scalar_in;

    v3alu_lane u_lane (
      .clk_i  (clk_i),
      .lane_i (lin),
      .prod_o (prod[i]),
      .res_o  (lres[i])
    );
  end

  // Merge the lane products into the dot product and the sum of squares.
  assign dot_d   = wide_t'(prod[0]) + wide_t'(prod[1]) + wide_t'(prod[2]);
  assign sumsq_d = $unsigned(prod[0]) + $unsigned(prod[1]) + $unsigned(prod[2]);

  always_ff @(posedge clk_i) begin
    dot_q   <= dot_d;
    sumsq_q <= sumsq_d;
  end

  // Results that are final after the lanes travel beside the long units.
  always_comb begin
    dot_sat       = sat_wide(dot_q >>> FB);
    side_d.cmd    = item2_q.cmd;
    side_d.a[0]   = item2_q.ax;
    side_d.a[1]   = item2_q.ay;
    side_d.a[2]   = item2_q.az;
    side_d.s_neg  = item2_q.scalar_in[DW-1];
    side_d.s_zero = (item2_q.scalar_in == '0);
    side_d.s_abs  = item2_q.scalar_in[DW-1] ? (~item2_q.scalar_in + 1'b1)
                                            : item2_q.scalar_in;
    unique case (item2_q.cmd)
      CMD_DOT: begin
        side_d.res  = '0;
        side_d.dot  = dot_sat.val;
        side_d.flag = dot_sat.flag;
      end
      CMD_ADD, CMD_SUB, CMD_SCALE, CMD_CROSS: begin
        side_d.res[0] = lres[0].val;
        side_d.res[1] = lres[1].val;
        side_d.res[2] = lres[2].val;
        side_d.dot    = '0;
        side_d.flag   = lres[0].flag | lres[1].flag | lres[2].flag;
      end
      default: begin
        side_d.res  = '0;
        side_d.dot  = '0;
        side_d.flag = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < SIDE_LEN; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // Magnitude of vector a.
  v3alu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .n_i    (sumsq_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    mag_q[0] <= root;
    for (int i = 1; i < DV_ST; i++) begin
      mag_q[i] <= mag_q[i-1];
    end
  end

  assign tap = side_q[SQ_ST-1];

  // Divider lanes on magnitudes; the sign is applied at the end.
  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [DW-1:0] aabs;
    logic [NW-1:0] num;
    logic [DW-1:0] den;
    assign aabs = tap.a[i][DW-1] ? (~tap.a[i] + 1'b1) : tap.a[i];
    assign num  = {aabs, {FB{1'b0}}};
    assign den  = (tap.cmd == CMD_DIV) ? tap.s_abs : root;

    v3alu_div u_div (
      .clk_i (clk_i),
      .num_i (num),
      .den_i (den),
      .quo_o (quo[i]),
      .ovf_o (ovf[i])
    );
  end

  assign fin  = side_q[SIDE_LEN-1];
  assign mfin = mag_q[DV_ST-1];

  // Signed, saturated quotient of one lane.
  function automatic sat_t div_fix(input logic [DW-1:0] q, input logic ov,
                                   input logic neg);
    sat_t r;
    r.flag = 1'b0;
    r.val  = q;
    if (ov) begin
      r.flag = 1'b1;
      r.val  = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else if (neg) begin
      if (q[DW-1] && (q[DW-2:0] != '0)) begin
        r.flag = 1'b1;
        r.val  = {1'b1, {(DW-1){1'b0}}};
      end else begin
        r.val = ~q + 1'b1;
      end
    end else if (q[DW-1]) begin
      r.flag = 1'b1;
      r.val  = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

  for (genvar i = 0; i < 3; i++) begin : g_fix
    assign dres[i] = div_fix(quo[i], ovf[i],
                             fin.a[i][DW-1] ^ ((fin.cmd == CMD_DIV) && fin.s_neg));
  end

  // Final merge and status.
  always_comb begin
    result_d.rx         = fin.res[0];
    result_d.ry         = fin.res[1];
    result_d.rz         = fin.res[2];
    result_d.scalar_out = fin.dot;
    result_d.status     = ST_OK;
    flag                = fin.flag;
    unique case (fin.cmd)
      CMD_DIV: begin
        if (fin.s_zero) begin
          result_d.rx = '0;
          result_d.ry = '0;
          result_d.rz = '0;
          flag        = 1'b0;
        end else begin
          result_d.rx = dres[0].val;
          result_d.ry = dres[1].val;
          result_d.rz = dres[2].val;
          flag        = dres[0].flag | dres[1].flag | dres[2].flag;
        end
      end
      CMD_MAG: begin
        flag                = mfin[DW-1];
        result_d.scalar_out = mfin[DW-1] ? {1'b0, {(DW-1){1'b1}}} : mfin;
      end
      CMD_NORM: begin
        if (mfin == '0) begin
          result_d.rx = fin.a[0];
          result_d.ry = fin.a[1];
          result_d.rz = fin.a[2];
          flag        = 1'b0;
        end else begin
          result_d.rx = dres[0].val;
          result_d.ry = dres[1].val;
          result_d.rz = dres[2].val;
          flag        = dres[0].flag | dres[1].flag | dres[2].flag;
        end
      end
      default: begin
      end
    endcase
    if ((fin.cmd == CMD_DIV) && fin.s_zero) begin
      result_d.status = ST_DIVZ;
    end else if (flag) begin
      result_d.status = ST_SAT;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o       = result_q;
  assign result_valid_o = vld_q[LAT];

endmodule

// ===== rtl/v3alu_checker.sv =====
// ----------------------------------------------------------------------------
// v3alu_checker
// Port-level checks of the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "vector3_alu_assert.svh"

module v3alu_checker import v3alu_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input item_t   item_i,
  input result_t result_o,
  input logic    result_valid_o
);

  logic in_acc;
  logic dot_in;
  logic vec_zero;
  logic all_zero;
  logic divz_out;
  logic scl_out;

  // Handshake and result shorthands for the checks below.
  assign in_acc   = start && !busy;
  assign dot_in   = in_acc && (item_i.cmd == CMD_DOT);
  assign vec_zero = (result_o.rx == '0) && (result_o.ry == '0) && (result_o.rz == '0);
  assign all_zero = vec_zero && (result_o.scalar_out == '0);
  assign divz_out = result_valid_o && (result_o.status == ST_DIVZ);
  assign scl_out  = result_valid_o && (result_o.scalar_out != '0);

  // Every accepted transaction produces its result at the fixed depth.
  `V3A_ASSERT_DLY(a_latency, in_acc, LAT + 1, result_valid_o, "result missing at fixed latency")

  // A dot product leaves the result vector at zero.
  `V3A_ASSERT_DLY(a_dot_vec_zero, dot_in, LAT + 1, vec_zero, "dot product with nonzero vector")

  // A divide by zero clears every value.
  `V3A_ASSERT_IMP(a_divz_zero, divz_out, all_zero, "divide by zero with nonzero output")

  // Scalar and vector results never appear together.
  `V3A_ASSERT_IMP(a_scalar_excl, scl_out, vec_zero, "scalar and vector result together")

endmodule

bind vector3_alu v3alu_checker u_v3alu_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-component vector ALU. Directed corner
// transactions and about 2000 random ones go in with random gaps between
// them. A predictor works out each result, and the results are checked field
// by field in order of entry.
// ----------------------------------------------------------------------------
module testbench;
  import v3alu_pkg::*;

  typedef logic signed [79:0] big_t;

  localparam int NUM_RANDOM = 2000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  result_t result_o;
  logic    result_valid_o;

  result_t expected_results[$];
  int      mismatch_count = 0;

  vector3_alu u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // Free-running clock with a period of 10.
  always #5 clk_i = ~clk_i;

  // Clamp a wide value to the word range and note any clamping.
  function automatic word_t clamp_word(input big_t v, inout logic clamped);
    big_t hi;
    big_t lo;
    hi = big_t'(32'sh7fffffff);
    lo = -hi - 1;
    if (v > hi) begin
      clamped = 1'b1;
      return word_t'(hi);
    end else if (v < lo) begin
      clamped = 1'b1;
      return word_t'(lo);
    end
    return word_t'(v);
  endfunction

  // Floor of the square root of a 64-bit value, one bit at a time.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Length of vector a, not yet clamped.
  function automatic logic [63:0] vector_length(input item_t it);
    logic [63:0] acc;
    big_t        c[3];
    acc = '0;
    c[0] = big_t'(it.ax);
    c[1] = big_t'(it.ay);
    c[2] = big_t'(it.az);
    for (int i = 0; i < 3; i++) begin
      acc = acc + 64'(c[i] * c[i]);
    end
    return floor_sqrt(acc);
  endfunction

  // Expected result of one transaction.
  function automatic result_t alu_result(input item_t it);
    result_t     r;
    big_t        a[3];
    big_t        b[3];
    big_t        s;
    big_t        len;
    logic [63:0] root;
    logic        clamped;
    word_t       v[3];
    r = '0;
    clamped = 1'b0;
    a[0] = big_t'(it.ax);
    a[1] = big_t'(it.ay);
    a[2] = big_t'(it.az);
    b[0] = big_t'(it.bx);
    b[1] = big_t'(it.by);
    b[2] = big_t'(it.bz);
    s = big_t'(it.scalar_in);
    for (int i = 0; i < 3; i++) v[i] = '0;
    case (it.cmd)
      CMD_ADD: for (int i = 0; i < 3; i++) v[i] = clamp_word(a[i] + b[i], clamped);
      CMD_SUB: for (int i = 0; i < 3; i++) v[i] = clamp_word(a[i] - b[i], clamped);
      CMD_SCALE: begin
        for (int i = 0; i < 3; i++) v[i] = clamp_word((a[i] * s) >>> FB, clamped);
      end
      CMD_DIV: begin
        if (s == 0) begin
          r.status = ST_DIVZ;
        end else begin
          for (int i = 0; i < 3; i++) v[i] = clamp_word((a[i] <<< FB) / s, clamped);
        end
      end
      CMD_DOT: begin
        r.scalar_out = clamp_word((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FB,
                                  clamped);
      end
      CMD_CROSS: begin
        v[0] = clamp_word((a[1] * b[2] - a[2] * b[1]) >>> FB, clamped);
        v[1] = clamp_word((a[2] * b[0] - a[0] * b[2]) >>> FB, clamped);
        v[2] = clamp_word((a[0] * b[1] - a[1] * b[0]) >>> FB, clamped);
      end
      CMD_MAG: begin
        root = vector_length(it);
        r.scalar_out = clamp_word(big_t'({1'b0, root}), clamped);
      end
      default: begin
        root = vector_length(it);
        len = big_t'({1'b0, root});
        // A zero vector comes back as it went in.
        if (len == 0) begin
          for (int i = 0; i < 3; i++) v[i] = word_t'(a[i]);
        end else begin
          for (int i = 0; i < 3; i++) v[i] = clamp_word((a[i] <<< FB) / len, clamped);
        end
      end
    endcase
    r.rx = v[0];
    r.ry = v[1];
    r.rz = v[2];
    if (r.status != ST_DIVZ && clamped) r.status = ST_SAT;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
  endtask

  // Check every result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(result_o.status), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (result_o.rx !== want.rx) report_mismatch("rx", result_o.rx, want.rx);
        if (result_o.ry !== want.ry) report_mismatch("ry", result_o.ry, want.ry);
        if (result_o.rz !== want.rz) report_mismatch("rz", result_o.rz, want.rz);
        if (result_o.scalar_out !== want.scalar_out) begin
          report_mismatch("scalar_out", result_o.scalar_out, want.scalar_out);
        end
        if (result_o.status !== want.status) begin
          report_mismatch("status", 32'(result_o.status), 32'(want.status));
        end
      end
    end
  end

  // Send one transaction after a random gap; start stays high afterwards.
  task automatic send_item(input item_t it);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_i = it;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    expected_results.push_back(alu_result(it));
    @(negedge clk_i);
  endtask

  function automatic item_t make_item(input cmd_e c, input word_t x, input word_t y,
                                      input word_t z, input word_t p, input word_t q,
                                      input word_t w, input word_t s);
    item_t it;
    it.cmd = c;
    it.ax = x;
    it.ay = y;
    it.az = z;
    it.bx = p;
    it.by = q;
    it.bz = w;
    it.scalar_in = s;
    return it;
  endfunction

  // Random word: full range, small Q16.16 values, or an extreme.
  function automatic word_t random_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return word_t'($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      3: return word_t'($urandom_range(0, 2)) - 1;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic test_corners();
    word_t mx;
    word_t mn;
    word_t one;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    one = 32'sh00010000;
    send_item(make_item(CMD_ADD, mx, mn, 1, mx, mn, -1, 0));
    send_item(make_item(CMD_ADD, one, one, one, one, -one, 0, 0));
    send_item(make_item(CMD_SUB, mn, mx, 0, 1, -1, mn, 0));
    send_item(make_item(CMD_SUB, one, 2 * one, 0, one, one, 0, 0));
    send_item(make_item(CMD_SCALE, mx, mn, -one, 0, 0, 0, mx));
    send_item(make_item(CMD_SCALE, one, -one, 3, 0, 0, 0, -1));
    send_item(make_item(CMD_SCALE, mn, 1, -1, 0, 0, 0, mn));
    send_item(make_item(CMD_DIV, one, -one, mx, 0, 0, 0, 0));
    send_item(make_item(CMD_DIV, mx, mn, one, 0, 0, 0, 1));
    send_item(make_item(CMD_DIV, mn, 7, -7, 0, 0, 0, -1));
    send_item(make_item(CMD_DIV, 3 * one, -one, 5, 0, 0, 0, 2 * one));
    send_item(make_item(CMD_DOT, mx, mx, mx, mx, mx, mx, 0));
    send_item(make_item(CMD_DOT, mn, mn, mn, mx, mx, mx, 0));
    send_item(make_item(CMD_DOT, one, 2 * one, -one, one, -one, 3, 0));
    send_item(make_item(CMD_CROSS, mx, mn, mx, mn, mx, mn, 0));
    send_item(make_item(CMD_CROSS, one, 0, 0, 0, one, 0, 0));
    send_item(make_item(CMD_MAG, mn, mn, mn, 0, 0, 0, 0));
    send_item(make_item(CMD_MAG, 3 * one, 4 * one, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_MAG, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_NORM, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_NORM, 1, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_NORM, mn, mx, mn, 0, 0, 0, 0));
    send_item(make_item(CMD_NORM, 3 * one, -4 * one, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random();
    item_t it;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      it = make_item(cmd_e'($urandom_range(0, 7)), random_word(), random_word(),
                     random_word(), random_word(), random_word(), random_word(),
                     random_word());
      send_item(it);
    end
  endtask

  task automatic drain_results();
    int waited;
    start = 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 10000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (LAT + 10) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_corners();
    test_random();
    drain_results();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("vector3_alu test passed");
    end else begin
      $display("vector3_alu test failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("vector3_alu test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/v3alu_pkg.sv
rtl/v3alu_lane.sv
rtl/v3alu_sqrt.sv
rtl/v3alu_div.sv
rtl/vector3_alu.sv
rtl/v3alu_checker.sv
verif/testbench.sv
